@@ rtl/core/ordered_list_insert_delete_dump_assert.svh @@
// assertion macros for the ordered list block
// used by ordered_list_insert_delete_dump.sv, expects clk and rst_n in scope
`ifndef ORDERED_LIST_INSERT_DELETE_DUMP_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_DUMP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define OLDD_ASSERT_NOW(label, cond_a, cond_b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |-> (cond_b)) \
    else $error("oldd assertion failed");

// next-cycle implication, disabled during reset
`define OLDD_ASSERT_NEXT(label, cond_a, cond_b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |=> (cond_b)) \
    else $error("oldd assertion failed");

`endif

@@ rtl/core/oldd_pkg.sv @@
// shared constants and types for the ordered list block
// no dependencies
package oldd_pkg;

  localparam int CAPACITY = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 5;
  localparam int REQ_W    = 2;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_FRONT  = 2'd0,
    REQ_BACK   = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

endpackage

@@ rtl/core/ordered_list_insert_delete_dump.sv @@
// ordered list with insert front/back, delete at position and full dump
// depends on oldd_pkg and ordered_list_insert_delete_dump_assert.svh
//
// Usage: a request word is taken on a rising edge with start high and busy
// low. Fields: in_req_type (0 insert front, 1 insert back, 2 delete at
// in_position), in_item_value, in_position. After every request the whole
// list is sent front to back, one word per cycle, each marked by out_valid
// for exactly one cycle; out_last marks the final word, out_dropped is set
// on every word of a dump whose insert hit a full list. An empty list sends
// nothing. The receiver cannot stall the output.
// Storage is a circular buffer in a single-port-read memory with a head
// pointer, so an insert moves no element. A delete moves each following
// element one place towards the front, one element per cycle through the
// memory read port, and ST_FIN writes back the last one. The first word
// comes from ST_DUMP through the registered memory read, after ST_MOVE
// and ST_FIN on a delete that moves elements. busy stays high until the
// dump is issued, so a new request waits for it. The memory read port
// sets the pace.
// Reset empties the list; memory contents are left as they are.
module ordered_list_insert_delete_dump
  import oldd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [REQ_W-1:0] in_req_type,
  input  logic [VAL_W-1:0] in_item_value,
  input  logic [POS_W-1:0] in_position,
  output logic             out_valid,
  output logic [VAL_W-1:0] out_elem_value,
  output logic             out_last,
  output logic             out_dropped
);

  `include "ordered_list_insert_delete_dump_assert.svh"

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MOVE = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_DUMP = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [ADDR_W-1:0]  prev_r, prev_nxt;
  logic [ADDR_W-1:0]  mv_dst_r, mv_dst_nxt;
  logic               mv_pend_r, mv_pend_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               rd_last_r, rd_last_nxt;
  logic               drop_r, drop_nxt;
  logic [VAL_W-1:0]   rd_data_r;
  logic [VAL_W-1:0]   list_mem [CAPACITY];

  logic               accept;
  logic               full;
  logic               is_insert;
  logic [CNT_W:0]     pos_ext;
  logic [CNT_W-1:0]   ph_in;
  logic [CNT_W:0]     ph_sum;
  logic [CNT_W:0]     ph_wrap;
  logic [ADDR_W-1:0]  ph_addr;
  logic [ADDR_W-1:0]  head_dec;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [VAL_W-1:0]   wr_data;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign is_insert = (in_req_type == REQ_FRONT) || (in_req_type == REQ_BACK);
  assign pos_ext   = (CNT_W+1)'(in_position);
  assign head_dec  = (head_r == '0) ? ADDR_W'(CAPACITY - 1) : head_r - ADDR_W'(1);

  // shared index unit: logical index to buffer address
  always_comb begin
    unique case (state_r)
      ST_IDLE: ph_in = (in_req_type == REQ_BACK) ? count_r : CNT_W'(in_position);
      default: ph_in = idx_r;
    endcase
    ph_sum  = (CNT_W+1)'(head_r) + (CNT_W+1)'(ph_in);
    ph_wrap = (ph_sum >= (CNT_W+1)'(CAPACITY)) ? ph_sum - (CNT_W+1)'(CAPACITY) : ph_sum;
    ph_addr = ph_wrap[ADDR_W-1:0];
  end

  // memory write port: move write-back or insert
  always_comb begin
    wr_en   = mv_pend_r || (accept && is_insert && !full);
    wr_data = mv_pend_r ? rd_data_r : in_item_value;
    if (mv_pend_r) begin
      wr_addr = mv_dst_r;
    end else if (in_req_type == REQ_FRONT) begin
      wr_addr = head_dec;
    end else begin
      wr_addr = ph_addr;
    end
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    prev_nxt    = prev_r;
    mv_dst_nxt  = mv_dst_r;
    mv_pend_nxt = 1'b0;
    rd_pend_nxt = 1'b0;
    rd_last_nxt = rd_last_r;
    drop_nxt    = drop_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          drop_nxt  = 1'b0;
          idx_nxt   = '0;
          state_nxt = ST_DUMP;
          priority if (is_insert && full) begin
            drop_nxt = 1'b1;
          end else if (in_req_type == REQ_FRONT) begin
            head_nxt  = head_dec;
            count_nxt = count_r + CNT_W'(1);
          end else if (in_req_type == REQ_BACK) begin
            count_nxt = count_r + CNT_W'(1);
          end else if (in_req_type == REQ_DELETE && pos_ext < (CNT_W+1)'(count_r)) begin
            if (pos_ext == (CNT_W+1)'(count_r) - (CNT_W+1)'(1)) begin
              count_nxt = count_r - CNT_W'(1);
            end else begin
              prev_nxt  = ph_addr;
              idx_nxt   = CNT_W'(pos_ext + (CNT_W+1)'(1));
              state_nxt = ST_MOVE;
            end
          end else begin
            count_nxt = count_r;
          end
        end
      end
      ST_MOVE: begin
        // read one element, write it back one place nearer the front
        mv_pend_nxt = 1'b1;
        mv_dst_nxt  = prev_r;
        prev_nxt    = ph_addr;
        idx_nxt     = idx_r + CNT_W'(1);
        if (idx_r == count_r - CNT_W'(1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        count_nxt = count_r - CNT_W'(1);
        idx_nxt   = '0;
        state_nxt = ST_DUMP;
      end
      ST_DUMP: begin
        if (count_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          rd_pend_nxt = 1'b1;
          rd_last_nxt = (idx_r == count_r - CNT_W'(1));
          idx_nxt     = idx_r + CNT_W'(1);
          if (idx_r == count_r - CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      head_r    <= '0;
      count_r   <= '0;
      mv_pend_r <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      mv_pend_r <= mv_pend_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    prev_r    <= prev_nxt;
    mv_dst_r  <= mv_dst_nxt;
    rd_last_r <= rd_last_nxt;
    drop_r    <= drop_nxt;
  end

  // list memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      list_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= list_mem[ph_addr];
  end

  // output word
  assign out_valid      = rd_pend_r;
  assign out_elem_value = rd_data_r;
  assign out_last       = rd_last_r;
  assign out_dropped    = drop_r;

  `OLDD_ASSERT_NOW(a_count_range, 1'b1, count_r <= CNT_W'(CAPACITY))
  `OLDD_ASSERT_NOW(a_out_nonempty, out_valid, count_r != '0)
  `OLDD_ASSERT_NEXT(a_busy_after_accept, accept, busy)
  `OLDD_ASSERT_NEXT(a_last_ends_dump, out_valid && out_last, !out_valid)
  `OLDD_ASSERT_NOW(a_fin_after_move, state_r == ST_FIN, $past(state_r == ST_MOVE))

endmodule
